/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Combinational or same-cycle property, checked on every rising clock edge.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* design/lph_pkg.sv */
// ---------------------------------------------------------------------------
// lph_pkg
// Shared widths, operation and status codes of the linear probe hash table.
// ---------------------------------------------------------------------------
`default_nettype none

package lph_pkg;

  localparam int MAX_SLOTS_DEF = 256;

  localparam int OP_W   = 2;
  localparam int KEY_W  = 31;
  localparam int ST_W   = 2;
  localparam int SLOT_W = 8;
  localparam int SIZE_W = 9;

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 9'd256;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_INVALID   = 2'd3;

endpackage

`default_nettype wire

/* design/lph_ifs.sv */
// ---------------------------------------------------------------------------
// lph_ifs
// Valid/ready channels: request, response and table size write.
// ---------------------------------------------------------------------------
`default_nettype none

interface lph_req_if import lph_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [KEY_W-1:0]  key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface

interface lph_rsp_if import lph_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink   (input valid, input status, input slot, output ready);
endinterface

interface lph_cfg_if import lph_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] table_size;

  modport source (output valid, output table_size, input ready);
  modport sink   (input valid, input table_size, output ready);
endinterface

`default_nettype wire

/* design/linear_probe_hash_table_core.sv */
// ---------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open addressing key table with linear probing: insert, delete, search.
// ---------------------------------------------------------------------------
//  channel  | dir | payload                   | transfer when
//  ---------+-----+---------------------------+---------------------------
//  in_ch    | in  | operation[1:0], key[30:0] | in_ch.valid & in_ch.ready
//  out_ch   | out | status[1:0], slot[7:0]    | out_ch.valid & out_ch.ready
//  cfg_ch   | in  | table_size[8:0]           | cfg_ch.valid & cfg_ch.ready
//
//  One item at a time: accept (S_IDLE), bit-serial home slot remainder over
//  the key bits (S_DIV), probing that reads up to n slots (S_PROBE), result
//  (S_RESP); n is table_size with zero as one, capped at MAX_SLOTS. Invalid
//  keys and unused codes go from accept straight to result. After reset the
//  key RAM is swept to zero with in_ch held off. The result cycle holds
//  while out_ch still shows an untaken result.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module linear_probe_hash_table_core import lph_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lph_req_if.sink    in_ch,
  lph_rsp_if.source  out_ch,
  lph_cfg_if.sink    cfg_ch
);

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int NW = $clog2(MAX_SLOTS + 1);
  localparam int CW = (NW > SIZE_W) ? NW : SIZE_W;
  localparam int DW = $clog2(KEY_W);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_DIV   = 5'b00100,
    S_PROBE = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [IW-1:0]      clr_r, clr_nxt;
  logic [SIZE_W-1:0]  table_size_r;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [KEY_W-1:0]   want_r, want_nxt;
  logic [KEY_W-1:0]   dkey_r, dkey_nxt;
  logic [DW-1:0]      dcnt_r, dcnt_nxt;
  logic [NW-1:0]      n_r, n_nxt;
  logic [NW-1:0]      rem_r, rem_nxt;
  logic [IW-1:0]      pos_r, pos_nxt;
  logic [NW-1:0]      iss_r, iss_nxt;
  logic               rvld_r, rvld_nxt;
  logic [IW-1:0]      rpos_r, rpos_nxt;
  logic [ST_W-1:0]    res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]  res_slot_r, res_slot_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]    out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;

  logic [CW-1:0]      ts_ext;
  logic [CW-1:0]      n_live;
  logic [NW:0]        shifted;
  logic               issue;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [KEY_W-1:0]   ram_wdata;
  logic [KEY_W-1:0]   ram_rdata;

  lph_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  assign in_ch.ready   = (state_r == S_IDLE);
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.slot   = out_slot_r;

  // Effective size: zero acts as one, clamp to the RAM depth.
  always_comb begin
    ts_ext = CW'(table_size_r);
    if (ts_ext == '0) begin
      n_live = CW'(1);
    end else if (ts_ext > CW'(MAX_SLOTS)) begin
      n_live = CW'(MAX_SLOTS);
    end else begin
      n_live = ts_ext;
    end
  end

  assign shifted = {rem_r, dkey_r[KEY_W-1]};
  assign issue   = (state_r == S_PROBE) && (iss_r < n_r);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    want_nxt       = want_r;
    dkey_nxt       = dkey_r;
    dcnt_nxt       = dcnt_r;
    n_nxt          = n_r;
    rem_nxt        = rem_r;
    pos_nxt        = pos_r;
    iss_nxt        = iss_r;
    rvld_nxt       = 1'b0;
    rpos_nxt       = pos_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    ram_we         = 1'b0;
    ram_waddr      = rpos_r;
    ram_wdata      = '0;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + IW'(1);
        if (clr_r == IW'(MAX_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt       = in_ch.operation;
          key_nxt      = in_ch.key;
          dkey_nxt     = in_ch.key;
          want_nxt     = (in_ch.operation == OP_INSERT) ? '0 : in_ch.key;
          n_nxt        = NW'(n_live);
          rem_nxt      = '0;
          dcnt_nxt     = '0;
          res_slot_nxt = '0;
          if (in_ch.operation != OP_INSERT && in_ch.operation != OP_DELETE &&
              in_ch.operation != OP_SEARCH) begin
            res_status_nxt = ST_NOT_FOUND;
            state_nxt      = S_RESP;
          end else if (in_ch.key == '0) begin
            res_status_nxt = ST_INVALID;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end

      S_DIV: begin
        // Restoring remainder, one key bit per cycle, MSB first.
        if (shifted >= {1'b0, n_r}) begin
          rem_nxt = NW'(shifted - {1'b0, n_r});
        end else begin
          rem_nxt = NW'(shifted);
        end
        dkey_nxt = dkey_r << 1;
        dcnt_nxt = dcnt_r + DW'(1);
        if (dcnt_r == DW'(KEY_W - 1)) begin
          pos_nxt   = IW'(rem_nxt);
          iss_nxt   = '0;
          state_nxt = S_PROBE;
        end
      end

      S_PROBE: begin
        // Issue one read per cycle; compare the slot read in the previous cycle.
        if (issue) begin
          rvld_nxt = 1'b1;
          iss_nxt  = iss_r + NW'(1);
          if (CW'(pos_r) + CW'(1) == CW'(n_r)) begin
            pos_nxt = '0;
          end else begin
            pos_nxt = pos_r + IW'(1);
          end
        end
        if (rvld_r) begin
          if (ram_rdata == want_r) begin
            ram_we         = (op_r != OP_SEARCH);
            ram_wdata      = (op_r == OP_INSERT) ? key_r : '0;
            res_status_nxt = ST_OK;
            res_slot_nxt   = SLOT_W'(rpos_r);
            rvld_nxt       = 1'b0;
            state_nxt      = S_RESP;
          end else if (iss_r == n_r) begin
            res_status_nxt = (op_r == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
            res_slot_nxt   = '0;
            rvld_nxt       = 1'b0;
            state_nxt      = S_RESP;
          end
        end
      end

      S_RESP: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      rvld_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      table_size_r <= TABLE_SIZE_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rvld_r      <= rvld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        table_size_r <= cfg_ch.table_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    want_r       <= want_nxt;
    dkey_r       <= dkey_nxt;
    dcnt_r       <= dcnt_nxt;
    n_r          <= n_nxt;
    rem_r        <= rem_nxt;
    pos_r        <= pos_nxt;
    iss_r        <= iss_nxt;
    rpos_r       <= rpos_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  `ASSERT_IMPL(a_ram_write_src, clk, rst_n, ram_we, (state_r == S_CLEAR) || (state_r == S_PROBE && rvld_r), "key RAM written outside clear sweep or probe hit")
  `ASSERT_IMPL(a_probe_bound, clk, rst_n, state_r == S_PROBE, iss_r <= n_r, "probe issued more reads than table size")
  `ASSERT_IMPL(a_home_in_range, clk, rst_n, state_r == S_PROBE && iss_r == '0, CW'(pos_r) < CW'(n_r), "home slot outside table")
  `ASSERT_NEXT(a_out_from_resp, clk, rst_n, state_r != S_RESP && !(out_valid_r && !out_ch.ready), !out_valid_r, "result shown without a response cycle")

endmodule

`default_nettype wire

/* design/lph_ram.sv */
// ---------------------------------------------------------------------------
// lph_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module lph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
